[hdl/upcc_pkg.sv]
// Package for the UP model clause checker: constants, command codes and the
// structs passed between the store, the evaluator and the top level.
// No dependencies.
package upcc_pkg;

  // Largest variable index held in the polarity store
  localparam int unsigned MAX_VARS     = 4096;
  localparam int unsigned DEPTH        = MAX_VARS + 1;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned LIT_W        = 14;
  localparam int unsigned NV_W         = 13;
  localparam int unsigned NUM_VARS_RST = 4096;

  // Result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Saturation point of the unassigned literal count
  localparam logic [1:0] CNT_SAT = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_MODEL  = 2'd1,
    CMD_CLAUSE = 2'd2
  } cmd_e;

  // Decoded request held in the evaluation stage
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
    logic             neg;
    logic             in_range;
    logic             zero;
    logic             active;
    logic             last;
  } upcc_item_t;

  // Store write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [1:0]       data;
  } upcc_wr_t;

  // Result of one request
  typedef struct packed {
    logic valid;
    logic kind;
    logic up_satisfied;
    logic inconsistent;
    logic range_error;
  } upcc_res_t;

endpackage

[hdl/upcc_if.sv]
// Valid/ready channel interfaces for the UP model clause checker.
// Depends on nothing; request and result payloads are fixed widths.
interface upcc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [13:0] literal;
  logic               clause_active;
  logic               last;

  modport source (output valid, cmd, literal, clause_active, last, input ready);
  modport sink   (input valid, cmd, literal, clause_active, last, output ready);
endinterface

interface upcc_rsp_if;
  logic valid;
  logic ready;
  logic kind;
  logic up_satisfied;
  logic inconsistent;
  logic range_error;

  modport source (output valid, kind, up_satisfied, inconsistent, range_error, input ready);
  modport sink   (input valid, kind, up_satisfied, inconsistent, range_error, output ready);
endinterface

[hdl/up_model_clause_check.sv]
// UP model clause checker. Model and clause literal requests are taken one
// per cycle while the evaluation stage can pass its request on and no store
// sweep is running; each reads the polarity store and is evaluated with the
// registered read data, and its result loads the output register once that
// register has room. A clear request wipes the store with a sweep that writes
// one entry a cycle over all 4097 entries, and no new request is taken until
// it ends; the same sweep runs after reset before the first request is taken.
// num_vars may only be written while idle.
module up_model_clause_check
  import upcc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  upcc_req_if.sink        req_i,
  upcc_rsp_if.source      rsp_o,
  input  logic            cfg_we_i,
  input  logic [NV_W-1:0] cfg_wdata_i
);

  logic [NV_W-1:0]  nv_q;
  logic [NV_W-1:0]  bound;
  logic [LIT_W-1:0] lit_u, mag;
  upcc_item_t       item_d;
  upcc_item_t       s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_fire, s1_is_clear, out_free, accept;
  logic             busy;
  logic [1:0]       pol;
  upcc_res_t        res;
  upcc_wr_t         wr;
  logic             out_valid_q, out_valid_d;
  upcc_res_t        out_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= NV_W'(NUM_VARS_RST);
    end else if (cfg_we_i) begin
      nv_q <= cfg_wdata_i;
    end
  end

  // Decode the incoming literal
  assign lit_u = req_i.literal;
  assign mag   = lit_u[LIT_W-1] ? (~lit_u + 1'b1) : lit_u;
  assign bound = (nv_q < NV_W'(MAX_VARS)) ? nv_q : NV_W'(MAX_VARS);

  always_comb begin
    item_d.cmd      = cmd_e'(req_i.cmd);
    item_d.idx      = mag[IDX_W-1:0];
    item_d.neg      = lit_u[LIT_W-1];
    item_d.zero     = (mag == '0);
    item_d.in_range = (mag != '0) && (mag <= LIT_W'(bound));
    item_d.active   = req_i.clause_active;
    item_d.last     = req_i.last;
  end

  // Handshake: stage advances when it gives no result or its result has room
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && (!res.valid || out_free);
  assign s1_is_clear = s1_valid_q && (s1_q.cmd == CMD_CLEAR);
  assign req_i.ready = !busy && !s1_is_clear && (!s1_valid_q || s1_fire);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item_d;
    end
  end

  upcc_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (accept),
    .rd_addr_i     (item_d.idx),
    .wr_i          (wr),
    .clear_start_i (s1_fire && s1_is_clear),
    .rd_data_o     (pol),
    .busy_o        (busy)
  );

  upcc_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .fire_i  (s1_fire),
    .item_i  (s1_q),
    .pol_i   (pol),
    .res_o   (res),
    .wr_o    (wr)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && res.valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res.valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = out_q.kind;
  assign rsp_o.up_satisfied = out_q.up_satisfied;
  assign rsp_o.inconsistent = out_q.inconsistent;
  assign rsp_o.range_error  = out_q.range_error;

  // No request is taken while the store is being wiped
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !req_i.ready)
    else $error("request taken during store sweep");

  // No model write while the sweep owns the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !wr.en)
    else $error("store write during sweep");

  // A verdict never flags inconsistency, an acknowledgement never satisfies
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_o.valid |-> (rsp_o.kind ? !rsp_o.inconsistent : !rsp_o.up_satisfied))
    else $error("result fields disagree with kind");

endmodule

[hdl/upcc_store.sv]
// Polarity store: one synchronous memory entry per variable, clearing sweep
// and write forwarding. Depends on upcc_pkg.
module upcc_store
  import upcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  upcc_wr_t         wr_i,
  input  logic             clear_start_i,
  output logic [1:0]       rd_data_o,
  output logic             busy_o
);

  logic [1:0]       mem_q [DEPTH];
  logic [1:0]       rdata_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             busy_q, busy_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic             fwd_valid_q, fwd_valid_d;
  logic [IDX_W-1:0] fwd_addr_q;
  logic [1:0]       fwd_data_q;

  // Memory: sweep writes zeros, otherwise take the evaluator's write
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_idx_q] <= 2'b00;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q   <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // Advance the clearing sweep over every entry
  always_comb begin
    busy_d    = busy_q;
    clr_idx_d = clr_idx_q;
    if (clear_start_i) begin
      busy_d    = 1'b1;
      clr_idx_d = '0;
    end else if (busy_q) begin
      if (clr_idx_q == IDX_W'(MAX_VARS)) begin
        busy_d    = 1'b0;
        clr_idx_d = '0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  // Hold the latest write so a read issued at the same edge sees it
  always_comb begin
    fwd_valid_d = fwd_valid_q;
    if (clear_start_i || busy_q) begin
      fwd_valid_d = 1'b0;
    end else if (wr_i.en) begin
      fwd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      clr_idx_q   <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      clr_idx_q   <= clr_idx_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !busy_q) begin
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rdata_q;
  assign busy_o    = busy_q;

endmodule

[hdl/upcc_eval.sv]
// Evaluation stage: model literal update and per-clause accumulators that
// form the verdict. Depends on upcc_pkg.
module upcc_eval
  import upcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       fire_i,
  input  upcc_item_t item_i,
  input  logic [1:0] pol_i,
  output upcc_res_t  res_o,
  output upcc_wr_t   wr_o
);

  logic       true_q, true_d;
  logic [1:0] cnt_q, cnt_d;
  logic       err_q, err_d;
  logic       true_upd, err_upd;
  logic [1:0] cnt_upd;
  logic       own, comp;

  assign own  = item_i.neg ? pol_i[1] : pol_i[0];
  assign comp = item_i.neg ? pol_i[0] : pol_i[1];

  // Decode the request against the stored polarity
  always_comb begin
    true_d   = true_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    true_upd = true_q;
    cnt_upd  = cnt_q;
    err_upd  = err_q;
    res_o    = '0;
    wr_o     = '0;
    case (item_i.cmd)
      CMD_CLEAR: begin
        true_d = 1'b0;
        cnt_d  = '0;
        err_d  = 1'b0;
      end
      CMD_MODEL: begin
        res_o.valid        = valid_i;
        res_o.kind         = KIND_ACK;
        res_o.inconsistent = item_i.in_range && comp;
        res_o.range_error  = !item_i.in_range;
        wr_o.en            = fire_i && item_i.in_range;
        wr_o.addr          = item_i.idx;
        wr_o.data          = pol_i | (item_i.neg ? 2'b10 : 2'b01);
      end
      CMD_CLAUSE: begin
        if (item_i.in_range) begin
          if (own) begin
            true_upd = 1'b1;
          end else if (!comp && (cnt_q != CNT_SAT)) begin
            cnt_upd = cnt_q + 1'b1;
          end
        end else if (!(item_i.zero && item_i.last)) begin
          err_upd = 1'b1;
        end
        if (item_i.last) begin
          res_o.valid        = valid_i;
          res_o.kind         = KIND_VERDICT;
          res_o.up_satisfied = !item_i.active || true_upd || (cnt_upd == CNT_SAT);
          res_o.range_error  = err_upd;
          true_d             = 1'b0;
          cnt_d              = '0;
          err_d              = 1'b0;
        end else begin
          true_d = true_upd;
          cnt_d  = cnt_upd;
          err_d  = err_upd;
        end
      end
      default: begin
      end
    endcase
  end

  // Update the accumulators only when the request leaves the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      true_q <= 1'b0;
      cnt_q  <= '0;
      err_q  <= 1'b0;
    end else if (fire_i) begin
      true_q <= true_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

endmodule

[dv/up_model_clause_check_tb.sv]
// Testbench for up_model_clause_check: walks a directed table of requests, then
// random model loads and clause streams, checking each result against a predictor.
// Depends on upcc_pkg and the upcc_req_if / upcc_rsp_if interfaces.
module up_model_clause_check_tb;
  import upcc_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned SWEEP_QUIET = 4200;   // covers a full store wipe
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned WATCHDOG    = 20000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [13:0] literal;
    logic               active;
    logic               last;
  } request_t;

  typedef struct packed {
    logic kind;
    logic up_satisfied;
    logic inconsistent;
    logic range_error;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t out;
  } row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [NV_W-1:0] cfg_wdata_i;

  upcc_req_if req_bus ();
  upcc_rsp_if rsp_bus ();

  up_model_clause_check DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: polarity store, clause accumulators and the bound register
  logic [1:0]  polarity [0:MAX_VARS];
  logic        true_hit;
  logic [1:0]  free_count;
  logic        clause_bad;
  int unsigned var_limit;

  outcome_t    pending_outcomes [$];
  row_t        directed_rows [$];
  int unsigned mismatch_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  outcome_t    seen_out;
  outcome_t    due_out;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Wipe the store and the clause accumulators
  task automatic clear_store();
    for (int i = 0; i <= MAX_VARS; i++) polarity[i] = 2'b00;
    true_hit   = 1'b0;
    free_count = 2'd0;
    clause_bad = 1'b0;
  endtask

  // Work out what one accepted request does to the store and what it returns
  task automatic evaluate_request(input request_t r, output bit gives, output outcome_t o);
    int          lit;
    int unsigned mag;
    int unsigned bound;
    bit          neg;
    bit          ok;
    logic [1:0]  own;
    logic [1:0]  comp;
    gives = 1'b0;
    o     = '0;
    lit   = int'($signed(r.literal));
    neg   = lit < 0;
    mag   = neg ? -lit : lit;
    bound = (var_limit < MAX_VARS) ? var_limit : MAX_VARS;
    ok    = (mag != 0) && (mag <= bound);
    own   = neg ? 2'b10 : 2'b01;
    comp  = ~own;
    case (r.cmd)
      CMD_CLEAR: begin
        clear_store();
      end
      CMD_MODEL: begin
        gives  = 1'b1;
        o.kind = KIND_ACK;
        if (ok) begin
          o.inconsistent = |(polarity[mag] & comp);
          polarity[mag]  = polarity[mag] | own;
        end else begin
          o.range_error = 1'b1;
        end
      end
      CMD_CLAUSE: begin
        if (ok) begin
          if (|(polarity[mag] & own)) true_hit = 1'b1;
          else if (!(|(polarity[mag] & comp)) && free_count < CNT_SAT)
            free_count = free_count + 2'd1;
        end else if (!(mag == 0 && r.last)) begin
          clause_bad = 1'b1;
        end
        if (r.last) begin
          gives          = 1'b1;
          o.kind         = KIND_VERDICT;
          o.up_satisfied = !r.active || true_hit || (free_count >= CNT_SAT);
          o.range_error  = clause_bad;
          true_hit       = 1'b0;
          free_count     = 2'd0;
          clause_bad     = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request, hold it until taken, then record its expected result
  task automatic send_request(input request_t r, input bit typed, input outcome_t typed_out);
    bit       gives;
    outcome_t o;
    if ($urandom_range(99) < snd_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    req_bus.valid         <= 1'b1;
    req_bus.cmd           <= r.cmd;
    req_bus.literal       <= r.literal;
    req_bus.clause_active <= r.active;
    req_bus.last          <= r.last;
    do @(posedge clk_i); while (!req_bus.ready);
    evaluate_request(r, gives, o);
    if (gives) pending_outcomes.push_back(typed ? typed_out : o);
  endtask

  task automatic send_plain(input logic [1:0] cmd, input int lit, input logic act,
                            input logic lst);
    request_t r;
    r = '{cmd: cmd, literal: lit[13:0], active: act, last: lst};
    send_request(r, 1'b0, '0);
  endtask

  function automatic void add_row(input logic [1:0] cmd, input int lit, input logic act,
                                  input logic lst, input logic typed, input outcome_t out);
    row_t w;
    w.req   = '{cmd: cmd, literal: lit[13:0], active: act, last: lst};
    w.typed = typed;
    w.out   = out;
    directed_rows.push_back(w);
  endfunction

  // Mostly a small window of variables so the store gets hit; some edges and misses
  function automatic int pick_literal(input int unsigned bnd);
    int unsigned win;
    int unsigned sel;
    int unsigned mag;
    win = (bnd >= 1 && bnd < 12) ? bnd : 12;
    sel = $urandom_range(99);
    if (sel < 80)      mag = $urandom_range(win, 1);
    else if (sel < 88) mag = (bnd > 2) ? bnd - $urandom_range(2, 0) : bnd;
    else if (sel < 96) mag = $urandom_range(8192, bnd + 1);
    else               mag = 0;
    if (mag >= 8192 || $urandom_range(1)) return -int'(mag);
    return int'(mag);
  endfunction

  function automatic int unsigned bound_now();
    return (var_limit < MAX_VARS) ? var_limit : MAX_VARS;
  endfunction

  // Drain results, let any wipe finish, then write the variable count
  task automatic write_num_vars(input int unsigned value);
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SWEEP_QUIET) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[NV_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    var_limit    = value;
  endtask

  task automatic load_model(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_plain(CMD_MODEL, pick_literal(bound_now()), $urandom_range(1), $urandom_range(1));
  endtask

  // Random part: clears, model loads and clause streams with some noise mixed in
  task automatic run_random(input int unsigned n_items, input bit mid_drain,
                            input bit long_hold);
    int unsigned sent;
    int unsigned sel;
    int unsigned len;
    int unsigned burst;
    bit          end_mark;
    bit          act;
    bit          lst;
    bit          drained;
    sent    = 0;
    drained = 1'b0;
    send_plain(CMD_CLEAR, 0, 1'b1, 1'b0);
    load_model(8);
    sent = 9;
    // Hold the receiver off once the wipe is over, while requests keep coming
    if (long_hold) hold_req = LONG_HOLD;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (mid_drain && !drained && sent >= n_items / 2) begin
        // Pause the sender until every result is back
        req_bus.valid <= 1'b0;
        do @(posedge clk_i); while (pending_outcomes.size() != 0);
        drained = 1'b1;
      end
      if (sel < 2) begin
        send_plain(CMD_CLEAR, pick_literal(bound_now()), $urandom_range(1), $urandom_range(1));
        sent++;
      end else if (sel < 4) begin
        send_plain(CMD_UNUSED, $urandom_range(16383), $urandom_range(1), $urandom_range(1));
      end else if (sel < 28) begin
        burst = $urandom_range(6, 1);
        load_model(burst);
        sent += burst;
      end else begin
        len      = $urandom_range(5, 1);
        end_mark = ($urandom_range(9) == 0);
        act      = ($urandom_range(9) != 0);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(14) == 0) begin
            load_model(1);
            sent++;
          end
          lst = (k == len - 1) && !end_mark;
          send_plain(CMD_CLAUSE, pick_literal(bound_now()), lst ? act : $urandom_range(1), lst);
          sent++;
        end
        if (end_mark) begin
          send_plain(CMD_CLAUSE, 0, act, 1'b1);
          sent++;
        end
      end
    end
  endtask

  // Take results, compare with the oldest expectation and pace the ready line
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      seen_out = '{kind: rsp_bus.kind, up_satisfied: rsp_bus.up_satisfied,
                   inconsistent: rsp_bus.inconsistent, range_error: rsp_bus.range_error};
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: kind=%0d sat=%0d inc=%0d err=%0d",
                   seen_out.kind, seen_out.up_satisfied, seen_out.inconsistent,
                   seen_out.range_error);
      end else begin
        due_out = pending_outcomes.pop_front();
        if (seen_out != due_out) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected kind=%0d sat=%0d inc=%0d err=%0d,",
                     due_out.kind, due_out.up_satisfied, due_out.inconsistent,
                     due_out.range_error,
                     " got kind=%0d sat=%0d inc=%0d err=%0d",
                     seen_out.kind, seen_out.up_satisfied,
                     seen_out.inconsistent, seen_out.range_error);
        end
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Give up when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[up_model_clause_check] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    req_bus.valid         = 1'b0;
    req_bus.cmd           = CMD_CLEAR;
    req_bus.literal       = '0;
    req_bus.clause_active = 1'b0;
    req_bus.last          = 1'b0;
    rsp_bus.ready         = 1'b0;
    mismatch_count        = 0;
    hold_req              = 0;
    hold_left             = 0;
    quiet_cycles          = 0;
    snd_idle_pct          = 20;
    rcv_idle_pct          = 60;
    var_limit             = NUM_VARS_RST;
    clear_store();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, run with the reset value of the variable count
    add_row(CMD_CLAUSE, 5, 1, 1, 1, {KIND_VERDICT, 1'b0, 1'b0, 1'b0});
    add_row(CMD_MODEL, 5, 1, 0, 1, {KIND_ACK, 1'b0, 1'b0, 1'b0});
    add_row(CMD_MODEL, -5, 1, 0, 1, {KIND_ACK, 1'b0, 1'b1, 1'b0});
    add_row(CMD_MODEL, 0, 1, 0, 1, {KIND_ACK, 1'b0, 1'b0, 1'b1});
    add_row(CMD_MODEL, 4097, 0, 1, 1, {KIND_ACK, 1'b0, 1'b0, 1'b1});
    add_row(CMD_MODEL, 8191, 1, 1, 1, {KIND_ACK, 1'b0, 1'b0, 1'b1});
    add_row(CMD_MODEL, -8192, 0, 0, 1, {KIND_ACK, 1'b0, 1'b0, 1'b1});
    add_row(CMD_MODEL, 4096, 1, 0, 1, {KIND_ACK, 1'b0, 1'b0, 1'b0});
    add_row(CMD_MODEL, -1, 1, 0, 1, {KIND_ACK, 1'b0, 1'b0, 1'b0});
    // variable set both ways counts as true
    add_row(CMD_CLAUSE, -5, 1, 1, 0, '0);
    // false plus one unassigned, closed by an empty end marker
    add_row(CMD_CLAUSE, 1, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, 2, 0, 0, 0, '0);
    add_row(CMD_CLAUSE, 0, 1, 1, 0, '0);
    // repeated unassigned literal counts twice
    add_row(CMD_CLAUSE, 3, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, 3, 1, 1, 0, '0);
    // zero without last, then a deleted clause
    add_row(CMD_CLAUSE, 1, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, 0, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, -4096, 0, 1, 0, '0);
    // model literal inside a clause keeps the accumulators
    add_row(CMD_CLAUSE, 7, 1, 0, 0, '0);
    add_row(CMD_MODEL, 7, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, 8, 1, 1, 0, '0);
    add_row(CMD_UNUSED, -8192, 0, 1, 0, '0);
    add_row(CMD_CLEAR, 0, 1, 0, 0, '0);
    add_row(CMD_CLAUSE, 5, 1, 1, 1, {KIND_VERDICT, 1'b0, 1'b0, 1'b0});
    add_row(CMD_CLAUSE, 8191, 1, 1, 0, '0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].out);

    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // Bound of one, with a long receiver hold while requests keep coming
    write_num_vars(1);
    run_random(PHASE_ITEMS, 1'b0, 1'b1);

    snd_idle_pct = 60;
    rcv_idle_pct = 20;
    write_num_vars(0);
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    write_num_vars(8191);
    run_random(PHASE_ITEMS, 1'b1, 1'b0);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_num_vars($urandom_range(4095, 2));
    run_random(PHASE_ITEMS, 1'b0, 1'b0);

    // Let the last results come back, then settle
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[up_model_clause_check] OK");
    end else begin
      $display("[up_model_clause_check] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/upcc_pkg.sv
hdl/upcc_if.sv
hdl/upcc_store.sv
hdl/upcc_eval.sv
hdl/up_model_clause_check.sv
dv/up_model_clause_check_tb.sv
